/* rtl/modular_inverse_divider_macros.svh */
// Assertion macros shared by the modular inverse divider RTL.
`ifndef MODULAR_INVERSE_DIVIDER_MACROS_SVH
`define MODULAR_INVERSE_DIVIDER_MACROS_SVH

`ifndef SYNTHESIS

`define MID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define MID_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`else

`define MID_ASSERT(lbl, prop, msg)

`define MID_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

/* rtl/mid_pkg.sv */
// Shared constants, command and status types for the modular inverse divider.
package mid_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int SH_W       = $clog2(WORD_WIDTH);
    localparam int T_W        = WORD_WIDTH + 2;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_LOAD_DIV  = 4'd1,
        OP_UP        = 4'd2,
        OP_DOWN      = 4'd3,
        OP_LOAD_NUM  = 4'd4,
        OP_LOAD_GCD  = 4'd5,
        OP_DOWN_SWAP = 4'd6,
        OP_LOAD_MUL  = 4'd7,
        OP_MUL       = 4'd8,
        OP_OUT_OK    = 4'd9,
        OP_OUT_BAD   = 4'd10
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_small;
        logic can_up;
        logic sh_zero;
        logic rem_zero;
        logic d_zero;
        logic gcd_one;
        logic y_zero;
    } t_dp_status;

endpackage

/* rtl/modular_inverse_divider.sv */
// Top level of the modular inverse divider: modulus register, controller and datapath.
//
//   Channel   Direction  Handshake                  Payload
//   request   in         i_in_valid / o_in_stall    i_numerator, i_divisor
//   result    out        o_out_valid / i_out_stall  o_quotient, o_inverse, o_no_inverse
//   modulus   in         i_modulus_we               i_modulus_wdata
//
// One request is in flight at a time; a new one is taken only after the last result is loaded.
// Both reductions and each Euclid quotient shift up and subtract back down one bit per cycle, and
// the multiplier retires one inverse bit per cycle.
// A modulus below two goes straight to the failure result and a zero divisor skips the Euclid loop.
// Reset is synchronous and active low; it empties the block and sets the modulus to two.
// The result sits in an output register; a stalled result holds only the final handoff.
`include "modular_inverse_divider_macros.svh"

module modular_inverse_divider
    import mid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_modulus_we,
    input  logic [WORD_WIDTH-1:0] i_modulus_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [WORD_WIDTH-1:0] i_numerator,
    input  logic [WORD_WIDTH-1:0] i_divisor,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [WORD_WIDTH-1:0] o_quotient,
    output logic [WORD_WIDTH-1:0] o_inverse,
    output logic                  o_no_inverse
);

    logic [WORD_WIDTH-1:0] r_modulus, n_modulus;
    t_dp_cmd               dp_cmd;
    t_dp_status            dp_status;
    logic                  bad_nonzero;
    logic                  good_result;
    logic                  in_accept;

    assign n_modulus = i_modulus_we ? i_modulus_wdata : r_modulus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= WORD_WIDTH'(2);
        end else begin
            r_modulus <= n_modulus;
        end
    end

    mid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    mid_datapath u_datapath (
        .i_clk        (i_clk),
        .i_cmd        (dp_cmd),
        .i_modulus    (r_modulus),
        .i_numerator  (i_numerator),
        .i_divisor    (i_divisor),
        .o_status     (dp_status),
        .o_quotient   (o_quotient),
        .o_inverse    (o_inverse),
        .o_no_inverse (o_no_inverse)
    );

    assign bad_nonzero = o_out_valid && o_no_inverse &&
                         ((o_quotient != '0) || (o_inverse != '0));
    assign good_result = o_out_valid && !o_no_inverse;
    assign in_accept   = i_in_valid && !o_in_stall;

    // A result flagged as having no inverse carries zeros in both value fields.
    `MID_ASSERT_NEVER(a_bad_is_zero, bad_nonzero, "flagged result with nonzero fields")

    // A valid inverse is never zero.
    `MID_ASSERT(a_inverse_nonzero, good_result |-> (o_inverse != '0), "zero inverse marked valid")

    // After taking a request the block is busy on the next cycle.
    `MID_ASSERT(a_busy_after_accept, in_accept |=> o_in_stall, "request taken while busy")

endmodule

/* rtl/mid_datapath.sv */
// Datapath: shift-subtract reduction and Euclid unit, modular multiplier, result registers.
module mid_datapath
    import mid_pkg::*;
(
    input  logic                  i_clk,
    input  t_dp_cmd               i_cmd,
    input  logic [WORD_WIDTH-1:0] i_modulus,
    input  logic [WORD_WIDTH-1:0] i_numerator,
    input  logic [WORD_WIDTH-1:0] i_divisor,
    output t_dp_status            o_status,
    output logic [WORD_WIDTH-1:0] o_quotient,
    output logic [WORD_WIDTH-1:0] o_inverse,
    output logic                  o_no_inverse
);

    localparam int W = WORD_WIDTH;

    logic [W-1:0]          r_a,   n_a;
    logic [W-1:0]          r_b,   n_b;
    logic [W-1:0]          r_d,   n_d;
    logic [W-1:0]          r_num, n_num;
    logic [W-1:0]          r_inv, n_inv;
    logic signed [T_W-1:0] r_ta,  n_ta;
    logic signed [T_W-1:0] r_tb,  n_tb;
    logic [SH_W-1:0]       r_sh,  n_sh;
    logic [W-1:0]          r_quot_out, n_quot_out;
    logic [W-1:0]          r_inv_out,  n_inv_out;
    logic                  r_bad_out,  n_bad_out;

    logic [W:0]            b_dbl;
    logic                  fits;
    logic [W-1:0]          a_sub;
    logic signed [T_W-1:0] ta_sub;
    logic signed [T_W-1:0] ta_fix;
    logic [W:0]            acc_sum;
    logic [W:0]            acc_red;
    logic [W:0]            x_sum;
    logic [W:0]            x_red;

    always_comb begin
        b_dbl   = {r_b, 1'b0};
        fits    = (r_b <= r_a);
        a_sub   = fits ? (r_a - r_b) : r_a;
        ta_sub  = fits ? (r_ta - r_tb) : r_ta;
        ta_fix  = r_ta[T_W-1] ? (r_ta + $signed({2'b00, i_modulus})) : r_ta;
        acc_sum = {1'b0, r_a} + {1'b0, r_num};
        acc_red = (acc_sum >= {1'b0, i_modulus}) ? (acc_sum - {1'b0, i_modulus}) : acc_sum;
        x_sum   = {1'b0, r_num} + {1'b0, r_num};
        x_red   = (x_sum >= {1'b0, i_modulus}) ? (x_sum - {1'b0, i_modulus}) : x_sum;
    end

    always_comb begin
        o_status.mod_small = (i_modulus < W'(2));
        o_status.can_up    = !r_b[W-1] && (b_dbl <= {1'b0, r_a});
        o_status.sh_zero   = (r_sh == '0);
        o_status.rem_zero  = (a_sub == '0);
        o_status.d_zero    = (r_d == '0);
        o_status.gcd_one   = (r_a == W'(1));
        o_status.y_zero    = (r_b == '0);
    end

    always_comb begin
        n_a        = r_a;
        n_b        = r_b;
        n_d        = r_d;
        n_num      = r_num;
        n_inv      = r_inv;
        n_ta       = r_ta;
        n_tb       = r_tb;
        n_sh       = r_sh;
        n_quot_out = r_quot_out;
        n_inv_out  = r_inv_out;
        n_bad_out  = r_bad_out;
        case (i_cmd.op)
            OP_LOAD_DIV: begin
                n_a   = i_divisor;
                n_b   = i_modulus;
                n_num = i_numerator;
                n_sh  = '0;
            end
            OP_UP: begin
                if (o_status.can_up) begin
                    n_b  = b_dbl[W-1:0];
                    n_tb = r_tb <<< 1;
                    n_sh = r_sh + 1'b1;
                end
            end
            OP_DOWN: begin
                n_a = a_sub;
                if (r_sh != '0) begin
                    n_b  = r_b >> 1;
                    n_sh = r_sh - 1'b1;
                end
            end
            OP_LOAD_NUM: begin
                n_d  = r_a;
                n_a  = r_num;
                n_b  = i_modulus;
                n_sh = '0;
            end
            OP_LOAD_GCD: begin
                n_num = r_a;
                n_a   = i_modulus;
                n_b   = r_d;
                n_ta  = '0;
                n_tb  = T_W'(1);
                n_sh  = '0;
            end
            OP_DOWN_SWAP: begin
                if (r_sh == '0) begin
                    n_a  = r_b;
                    n_b  = a_sub;
                    n_ta = r_tb;
                    n_tb = ta_sub;
                end else begin
                    n_a  = a_sub;
                    n_ta = ta_sub;
                    n_b  = r_b >> 1;
                    n_tb = r_tb >>> 1;
                    n_sh = r_sh - 1'b1;
                end
            end
            OP_LOAD_MUL: begin
                n_inv = ta_fix[W-1:0];
                n_b   = ta_fix[W-1:0];
                n_a   = '0;
            end
            OP_MUL: begin
                if (r_b[0]) begin
                    n_a = acc_red[W-1:0];
                end
                n_num = x_red[W-1:0];
                n_b   = r_b >> 1;
            end
            OP_OUT_OK: begin
                n_quot_out = r_a;
                n_inv_out  = r_inv;
                n_bad_out  = 1'b0;
            end
            OP_OUT_BAD: begin
                n_quot_out = '0;
                n_inv_out  = '0;
                n_bad_out  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_d        <= n_d;
        r_num      <= n_num;
        r_inv      <= n_inv;
        r_ta       <= n_ta;
        r_tb       <= n_tb;
        r_sh       <= n_sh;
        r_quot_out <= n_quot_out;
        r_inv_out  <= n_inv_out;
        r_bad_out  <= n_bad_out;
    end

    assign o_quotient   = r_quot_out;
    assign o_inverse    = r_inv_out;
    assign o_no_inverse = r_bad_out;

endmodule

/* rtl/mid_ctrl.sv */
// Controller state machine sequencing reduction, Euclid, multiply and result handoff.
module mid_ctrl
    import mid_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RD_UP = 13'b0000000000010,
        S_RD_DN = 13'b0000000000100,
        S_RN_LD = 13'b0000000001000,
        S_RN_UP = 13'b0000000010000,
        S_RN_DN = 13'b0000000100000,
        S_G_LD  = 13'b0000001000000,
        S_G_UP  = 13'b0000010000000,
        S_G_DN  = 13'b0000100000000,
        S_G_END = 13'b0001000000000,
        S_MUL   = 13'b0010000000000,
        S_DONE  = 13'b0100000000000,
        S_FAIL  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   out_load;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NOP;
        o_in_stall = 1'b1;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_status.mod_small) begin
                        n_state = S_FAIL;
                    end else begin
                        o_cmd.op = OP_LOAD_DIV;
                        n_state  = S_RD_UP;
                    end
                end
            end
            S_RD_UP: begin
                o_cmd.op = OP_UP;
                if (!i_status.can_up) n_state = S_RD_DN;
            end
            S_RD_DN: begin
                o_cmd.op = OP_DOWN;
                if (i_status.sh_zero) n_state = S_RN_LD;
            end
            S_RN_LD: begin
                o_cmd.op = OP_LOAD_NUM;
                n_state  = S_RN_UP;
            end
            S_RN_UP: begin
                o_cmd.op = OP_UP;
                if (!i_status.can_up) n_state = S_RN_DN;
            end
            S_RN_DN: begin
                o_cmd.op = OP_DOWN;
                if (i_status.sh_zero) n_state = S_G_LD;
            end
            S_G_LD: begin
                if (i_status.d_zero) begin
                    n_state = S_FAIL;
                end else begin
                    o_cmd.op = OP_LOAD_GCD;
                    n_state  = S_G_UP;
                end
            end
            S_G_UP: begin
                o_cmd.op = OP_UP;
                if (!i_status.can_up) n_state = S_G_DN;
            end
            S_G_DN: begin
                o_cmd.op = OP_DOWN_SWAP;
                if (i_status.sh_zero) begin
                    n_state = i_status.rem_zero ? S_G_END : S_G_UP;
                end
            end
            S_G_END: begin
                if (!i_status.gcd_one) begin
                    n_state = S_FAIL;
                end else begin
                    o_cmd.op = OP_LOAD_MUL;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                if (i_status.y_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_MUL;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.op = OP_OUT_OK;
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_FAIL: begin
                if (out_free) begin
                    o_cmd.op = OP_OUT_BAD;
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
